>>> hw/rtl/mbsm_pkg.sv
package mbsm_pkg;

	// field and register widths fixed by the block's interface
	localparam int BYTE_W       = 8;
	localparam int CFG_DATA_W   = 64;
	localparam int CFG_INDEX_W  = 2;
	localparam int RULES_W      = 32;
	localparam int LEN_W        = 5;
	localparam int OFFSET_OUT_W = 32;
	localparam int CFG_POSITIONS = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PATTERN_LOW  = 2'd0,
		CFG_PATTERN_HIGH = 2'd1,
		CFG_RULES        = 2'd2,
		CFG_LENGTH       = 2'd3
	} cfg_reg_t;

	// per-position rule, two bits each
	typedef enum logic [1:0] {
		RULE_ANY     = 2'd0,
		RULE_EQUAL   = 2'd1,
		RULE_DIFFER  = 2'd2,
		RULE_ANY_ALT = 2'd3
	} rule_t;

	localparam logic [LEN_W-1:0] LENGTH_RESET = 5'd1;

endpackage

>>> hw/rtl/masked_byte_signature_matcher_unit.sv
// Masked byte signature matcher. Bytes of a region arrive one byte per cycle
// on the input channel; the last byte of a region carries last_in_region.
// Each of up to MAX_PATTERN_BYTES pattern positions has a rule (must equal,
// must differ, or any) taken from the configuration registers. The first
// window of the newest pattern_length bytes that satisfies every rule gives
// one found word with the offset of its first byte; later bytes of that
// region are dropped. A region that ends without a match gives one not-found
// word. The block takes one byte every cycle while not stalled; the input
// register feeds a single stage in which all positions are compared in
// parallel against the shifted byte window, and the result lands in the
// output register, from which the found or not-found word is presented.
// The input stalls only while a result waits in the output register and the
// output is stalled. Configuration is to be written only while the block is
// idle; pattern_length above MAX_PATTERN_BYTES is treated as the maximum.
module masked_byte_signature_matcher_unit #(
	parameter int MAX_PATTERN_BYTES = 16,
	parameter int OFFSET_BITS       = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [mbsm_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [mbsm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [mbsm_pkg::BYTE_W-1:0]           data_byte,
	input  logic                                  last_in_region,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  found,
	output logic [mbsm_pkg::OFFSET_OUT_W-1:0]     match_offset
);

	localparam int IDX_W     = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
	localparam int OFF_EXT_W = (OFFSET_BITS > mbsm_pkg::OFFSET_OUT_W) ?
		OFFSET_BITS : mbsm_pkg::OFFSET_OUT_W;
	localparam int PAT_W     = 2 * mbsm_pkg::CFG_DATA_W;

	// configuration registers
	logic [PAT_W-1:0]                    pattern_q;
	logic [mbsm_pkg::RULES_W-1:0]        rules_q;
	logic [mbsm_pkg::LEN_W-1:0]          pattern_length_q;

	// input register
	logic                                valid_s1;
	logic [mbsm_pkg::BYTE_W-1:0]         byte_s1;
	logic                                last_s1;

	// region state
	logic [mbsm_pkg::BYTE_W-1:0]         byte_window_q [MAX_PATTERN_BYTES];
	logic [OFFSET_BITS-1:0]              bytes_seen_q;
	logic                                reported_q;

	// result register
	logic                                out_valid_q;
	logic                                found_q;
	logic [mbsm_pkg::OFFSET_OUT_W-1:0]   offset_q;

	// stage logic
	logic                                advance;
	logic                                process;
	logic [mbsm_pkg::BYTE_W-1:0]         window_next [MAX_PATTERN_BYTES];
	logic [mbsm_pkg::LEN_W-1:0]          len_eff;
	logic [mbsm_pkg::LEN_W-1:0]          pos_idx [MAX_PATTERN_BYTES];
	logic [MAX_PATTERN_BYTES-1:0]        pos_ok;
	logic                                count_ok;
	logic [OFFSET_BITS-1:0]              seen_next;
	logic                                len_reached;
	logic                                hit;
	logic                                miss_at_end;
	logic [OFFSET_BITS-1:0]              offset_diff;
	logic [OFF_EXT_W-1:0]                offset_ext;

	// ---------------------------------------------------------------
	// configuration writes, extra data bits dropped
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q        <= '0;
			rules_q          <= '0;
			pattern_length_q <= mbsm_pkg::LENGTH_RESET;
		end else if (cfg_we) begin
			case (mbsm_pkg::cfg_reg_t'(cfg_index))
				mbsm_pkg::CFG_PATTERN_LOW: begin
					pattern_q[mbsm_pkg::CFG_DATA_W-1:0] <= cfg_wdata;
				end
				mbsm_pkg::CFG_PATTERN_HIGH: begin
					pattern_q[PAT_W-1:mbsm_pkg::CFG_DATA_W] <= cfg_wdata;
				end
				mbsm_pkg::CFG_RULES: begin
					rules_q <= cfg_wdata[mbsm_pkg::RULES_W-1:0];
				end
				mbsm_pkg::CFG_LENGTH: begin
					pattern_length_q <= cfg_wdata[mbsm_pkg::LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// handshake: the stage moves unless a result is stuck at the output
	// ---------------------------------------------------------------
	assign advance  = !out_valid_q || !out_stall;
	assign process  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_in_region;
		end
	end

	// ---------------------------------------------------------------
	// compare stage
	// ---------------------------------------------------------------
	// saturate length to the window depth
	assign len_eff = (pattern_length_q > mbsm_pkg::LEN_W'(MAX_PATTERN_BYTES)) ?
		mbsm_pkg::LEN_W'(MAX_PATTERN_BYTES) : pattern_length_q;

	// newest byte enters at slot 0
	always_comb begin
		window_next[0] = byte_s1;
		for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
			window_next[i] = byte_window_q[i-1];
		end
	end

	// position k sits at slot len-1-k; positions past the length always pass
	always_comb begin
		for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
			pos_idx[k] = len_eff - mbsm_pkg::LEN_W'(1) - mbsm_pkg::LEN_W'(k);
			if (mbsm_pkg::LEN_W'(k) >= len_eff) begin
				pos_ok[k] = 1'b1;
			end else begin
				case (mbsm_pkg::rule_t'(rules_q[2*k +: 2]))
					mbsm_pkg::RULE_EQUAL: begin
						pos_ok[k] = window_next[pos_idx[k][IDX_W-1:0]] ==
							pattern_q[mbsm_pkg::BYTE_W*k +: mbsm_pkg::BYTE_W];
					end
					mbsm_pkg::RULE_DIFFER: begin
						pos_ok[k] = window_next[pos_idx[k][IDX_W-1:0]] !=
							pattern_q[mbsm_pkg::BYTE_W*k +: mbsm_pkg::BYTE_W];
					end
					default: begin
						pos_ok[k] = 1'b1;
					end
				endcase
			end
		end
	end

	// counter saturates; once full no further match is tested
	assign count_ok    = bytes_seen_q != {OFFSET_BITS{1'b1}};
	assign seen_next   = bytes_seen_q + OFFSET_BITS'(1);
	assign len_reached = seen_next >= OFFSET_BITS'(len_eff);
	assign hit         = !reported_q && count_ok && (len_eff != '0) &&
		len_reached && (&pos_ok);
	assign miss_at_end = last_s1 && !reported_q && !hit;
	assign offset_diff = seen_next - OFFSET_BITS'(len_eff);
	assign offset_ext  = OFF_EXT_W'(offset_diff);

	// region state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
				byte_window_q[i] <= '0;
			end
			bytes_seen_q <= '0;
			reported_q   <= 1'b0;
		end else if (process) begin
			if (last_s1) begin
				// end of region clears everything
				for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
					byte_window_q[i] <= '0;
				end
				bytes_seen_q <= '0;
				reported_q   <= 1'b0;
			end else if (!reported_q) begin
				byte_window_q <= window_next;
				if (count_ok) begin
					bytes_seen_q <= seen_next;
				end
				if (hit) begin
					reported_q <= 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && (hit || miss_at_end);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			found_q  <= hit;
			offset_q <= hit ? offset_ext[mbsm_pkg::OFFSET_OUT_W-1:0] : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign match_offset = offset_q;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	// not-found words always carry a zero offset
	a_miss_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_offset == '0)
		else $error("not-found word with nonzero offset");

	// input backs up only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	// a byte after a reported match, before the end mark, gives no word
	a_quiet_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		process && reported_q && !last_s1 |=> !out_valid)
		else $error("word emitted after match in same region");

endmodule
